// ----- hdl/ospf_pkg.sv -----
// ----------------------------------------------------------------------------
// ospf_pkg
// Shared types and constants for the DR/BDR election block.
// ----------------------------------------------------------------------------
package ospf_pkg;

	localparam int unsigned NBR_DEF = 16;

	localparam logic [2:0] CMD_WRITE   = 3'd0;
	localparam logic [2:0] CMD_REMOVE  = 3'd1;
	localparam logic [2:0] CMD_UP      = 3'd2;
	localparam logic [2:0] CMD_WAIT    = 3'd3;
	localparam logic [2:0] CMD_NBRCHG  = 3'd4;
	localparam logic [2:0] CMD_DOWN    = 3'd5;

	localparam logic [2:0] ST_DOWN    = 3'd0;
	localparam logic [2:0] ST_WAITING = 3'd1;
	localparam logic [2:0] ST_P2P     = 3'd2;
	localparam logic [2:0] ST_DROTHER = 3'd3;
	localparam logic [2:0] ST_BDR     = 3'd4;
	localparam logic [2:0] ST_DR      = 3'd5;

	localparam logic CFG_ROUTER_ID = 1'b0;
	localparam logic CFG_PRIORITY  = 1'b1;

	// neighbor entry as stored in the table memory
	localparam int unsigned ENTRY_W = 32 + 8 + 1 + 32 + 32;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  slot;
		logic [31:0] nbr_router_id;
		logic [7:0]  nbr_priority;
		logic        nbr_twoway;
		logic [31:0] nbr_declared_dr;
		logic [31:0] nbr_declared_bdr;
		logic        link_up;
		logic        point_to_point;
	} req_t;

	typedef struct packed {
		logic [2:0]  iface_state;
		logic [31:0] dr_id;
		logic [31:0] bdr_id;
		logic        roles_changed;
		logic        start_wait_timer;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] dr;
		logic [31:0] bdr;
		logic [7:0]  prio;
		logic        elig;
	} cand_t;

	// candidate order: priority, then router id, earlier wins ties
	function automatic logic b_beats_a(input cand_t a, input cand_t b);
		logic r;
		if (a.prio != b.prio) r = b.prio > a.prio;
		else r = b.id > a.id;
		return r;
	endfunction

endpackage

// ----- hdl/ospf_ram.sv -----
// ----------------------------------------------------------------------------
// ospf_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ospf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/ospf_dr_bdr_election.sv -----
// ----------------------------------------------------------------------------
// ospf_dr_bdr_election
// OSPF interface state machine with DR and BDR election over a neighbor table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with done high, and the receiver cannot stall
// it. Table writes, removes, up and down events go straight to the response
// state. An election streams the neighbor table out of its RAM one slot a
// cycle, running the BDR and DR passes side by side, then makes the final
// pick with this router last. When this router's own role changes the final
// pick runs once more with the new own view; the neighbor winners are kept,
// so the table is not read again. The single read port of the table RAM sets
// the scan pace. Valid bits sit in flip-flops so down clears them at once.
module ospf_dr_bdr_election #(
	parameter int unsigned NEIGHBORS = ospf_pkg::NBR_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_wdata,
	input  logic                 start,
	input  ospf_pkg::req_t       req,
	output logic                 busy,
	output logic                 done,
	output ospf_pkg::rsp_t       rsp
);
	localparam int unsigned AW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
	localparam int unsigned CW = $clog2(NEIGHBORS + 1);

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_SCAN  = 3'd1;
	localparam logic [2:0] F_LAST  = 3'd2;
	localparam logic [2:0] F_FINAL = 3'd3;
	localparam logic [2:0] F_RESP  = 3'd4;

	// configuration
	logic [31:0] own_id_q;
	logic [7:0]  own_prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q   <= '0;
			own_prio_q <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ospf_pkg::CFG_ROUTER_ID: own_id_q   <= cfg_wdata;
				ospf_pkg::CFG_PRIORITY:  own_prio_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// interface state
	logic [2:0]          fsm_q;
	logic [2:0]          ist_q;
	logic [31:0]         dr_q, bdr_q;
	logic [NEIGHBORS-1:0] valid_q;
	logic                pass2_q;
	logic [CW-1:0]       cnt_q;
	logic                rd_vld_s1;
	logic [AW-1:0]       rd_slot_s1;
	logic                chg_q, stw_q;

	// running winners of the two passes
	logic         bb_vld_q, bd_vld_q;
	ospf_pkg::cand_t bb_q, bd_q;
	// own declared view and first-pass winners kept for the re-run
	logic [31:0]  me_dr_q, me_bdr_q;

	// table memory
	logic                 ram_we;
	logic [AW-1:0]        ram_raddr;
	logic [ospf_pkg::ENTRY_W-1:0] ram_rdata;
	logic                 slot_ok;
	logic [AW-1:0]        slot_a;

	assign slot_a  = AW'(req.slot);
	assign slot_ok = ({{(32-4){1'b0}}, req.slot} < 32'(NEIGHBORS));
	assign ram_we  = start && !busy && (req.command == ospf_pkg::CMD_WRITE) && slot_ok;
	assign ram_raddr = cnt_q[AW-1:0];

	ospf_ram #(.WIDTH(ospf_pkg::ENTRY_W), .DEPTH(NEIGHBORS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_a),
		.wdata ({req.nbr_router_id, req.nbr_priority, req.nbr_twoway,
			req.nbr_declared_dr, req.nbr_declared_bdr}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// candidate from the stream
	ospf_pkg::cand_t nc;
	always_comb begin
		nc.id   = ram_rdata[104:73];
		nc.prio = ram_rdata[72:65];
		nc.dr   = ram_rdata[63:32];
		nc.bdr  = ram_rdata[31:0];
		nc.elig = ram_rdata[64] && (ram_rdata[72:65] != 8'd0);
	end

	// own candidate
	ospf_pkg::cand_t me;
	always_comb begin
		me.id   = own_id_q;
		me.dr   = me_dr_q;
		me.bdr  = me_bdr_q;
		me.prio = own_prio_q;
		me.elig = own_prio_q != 8'd0;
	end

	// pick functions applied to a running winner and a newcomer
	function automatic logic take_bdr(input logic av, input ospf_pkg::cand_t a,
		input ospf_pkg::cand_t b);
		logic oa, ob, da, db, r;
		oa = av && a.elig && (a.dr != a.id);
		ob = b.elig && (b.dr != b.id);
		da = a.bdr == a.id;
		db = b.bdr == b.id;
		if (!ob) r = 1'b0;
		else if (!oa) r = 1'b1;
		else if (da != db) r = db;
		else r = ospf_pkg::b_beats_a(a, b);
		return r;
	endfunction

	function automatic logic take_dr(input logic av, input ospf_pkg::cand_t a,
		input ospf_pkg::cand_t b);
		logic oa, ob, r;
		oa = av && a.elig && (a.dr == a.id);
		ob = b.elig && (b.dr == b.id);
		if (!ob) r = 1'b0;
		else if (!oa) r = 1'b1;
		else r = ospf_pkg::b_beats_a(a, b);
		return r;
	endfunction

	// final pick with this router last
	logic tb_me, td_me;
	logic b_any, d_any;
	logic bdr_me, dr_me;
	logic [31:0] bdr_pick, dr_pick;
	always_comb begin
		tb_me  = take_bdr(bb_vld_q, bb_q, me);
		td_me  = take_dr(bd_vld_q, bd_q, me);
		b_any  = tb_me || (bb_vld_q && bb_q.elig && (bb_q.dr != bb_q.id));
		d_any  = td_me || (bd_vld_q && bd_q.elig && (bd_q.dr == bd_q.id));
		bdr_me = tb_me;
		bdr_pick = tb_me ? me.id : (b_any ? bb_q.id : 32'd0);
		// no DR candidate: BDR doubles as DR
		dr_me   = d_any ? td_me : bdr_me;
		dr_pick = d_any ? (td_me ? me.id : bd_q.id) : bdr_pick;
	end

	logic rerun;
	assign rerun = !pass2_q && ((dr_me != (me_dr_q == own_id_q)) ||
		(bdr_me != (me_bdr_q == own_id_q)));

	logic accept;
	assign accept = start && !busy;
	assign busy   = fsm_q != F_IDLE;

	logic elect_go;
	always_comb begin
		elect_go = 1'b0;
		if (req.command == ospf_pkg::CMD_WAIT)
			elect_go = ist_q == ospf_pkg::ST_WAITING;
		else if (req.command == ospf_pkg::CMD_NBRCHG)
			elect_go = (ist_q == ospf_pkg::ST_DROTHER) || (ist_q == ospf_pkg::ST_BDR)
				|| (ist_q == ospf_pkg::ST_DR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= F_IDLE;
			ist_q      <= ospf_pkg::ST_DOWN;
			dr_q       <= '0;
			bdr_q      <= '0;
			valid_q    <= '0;
			pass2_q    <= 1'b0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_slot_s1 <= '0;
			chg_q      <= 1'b0;
			stw_q      <= 1'b0;
			bb_vld_q   <= 1'b0;
			bd_vld_q   <= 1'b0;
			bb_q       <= '0;
			bd_q       <= '0;
			me_dr_q    <= '0;
			me_bdr_q   <= '0;
		end else begin
			unique case (fsm_q)
				F_IDLE: begin
					if (accept) begin
						chg_q <= 1'b0;
						stw_q <= 1'b0;
						fsm_q <= F_RESP;
						case (req.command)
							ospf_pkg::CMD_WRITE:
								if (slot_ok) valid_q[slot_a] <= 1'b1;
							ospf_pkg::CMD_REMOVE:
								if (slot_ok) valid_q[slot_a] <= 1'b0;
							ospf_pkg::CMD_UP:
								if (req.link_up && ist_q == ospf_pkg::ST_DOWN) begin
									if (req.point_to_point) ist_q <= ospf_pkg::ST_P2P;
									else if (own_prio_q == 8'd0)
										ist_q <= ospf_pkg::ST_DROTHER;
									else begin
										ist_q <= ospf_pkg::ST_WAITING;
										stw_q <= 1'b1;
									end
								end
							ospf_pkg::CMD_DOWN: begin
								ist_q   <= ospf_pkg::ST_DOWN;
								valid_q <= '0;
								dr_q    <= '0;
								bdr_q   <= '0;
							end
							default: ;
						endcase
						if (elect_go) begin
							fsm_q    <= F_SCAN;
							pass2_q  <= 1'b0;
							cnt_q    <= '0;
							bb_vld_q <= 1'b0;
							bd_vld_q <= 1'b0;
							me_dr_q  <= dr_q;
							me_bdr_q <= bdr_q;
						end
					end
				end
				F_SCAN: begin
					// issue reads, fold in each slot's data in the cycle after its read
					rd_vld_s1  <= 1'b1;
					rd_slot_s1 <= cnt_q[AW-1:0];
					if (cnt_q == CW'(NEIGHBORS - 1)) fsm_q <= F_LAST;
					cnt_q <= cnt_q + 1'b1;
					if (rd_vld_s1 && valid_q[rd_slot_s1]) begin
						if (take_bdr(bb_vld_q, bb_q, nc)) begin
							bb_q <= nc; bb_vld_q <= 1'b1;
						end
						if (take_dr(bd_vld_q, bd_q, nc)) begin
							bd_q <= nc; bd_vld_q <= 1'b1;
						end
					end
				end
				F_LAST: begin
					rd_vld_s1 <= 1'b0;
					if (rd_vld_s1 && valid_q[rd_slot_s1]) begin
						if (take_bdr(bb_vld_q, bb_q, nc)) begin
							bb_q <= nc; bb_vld_q <= 1'b1;
						end
						if (take_dr(bd_vld_q, bd_q, nc)) begin
							bd_q <= nc; bd_vld_q <= 1'b1;
						end
					end
					fsm_q <= F_FINAL;
				end
				F_FINAL: begin
					if (rerun) begin
						// own role moved: fold again with the new own view;
						// neighbor winners are unchanged, only this router differs
						pass2_q  <= 1'b1;
						me_dr_q  <= dr_pick;
						me_bdr_q <= bdr_pick;
					end else begin
						chg_q <= (dr_pick != dr_q) || (bdr_pick != bdr_q);
						dr_q  <= dr_pick;
						bdr_q <= bdr_pick;
						if (dr_me) ist_q <= ospf_pkg::ST_DR;
						else if (bdr_me) ist_q <= ospf_pkg::ST_BDR;
						else ist_q <= ospf_pkg::ST_DROTHER;
						fsm_q <= F_RESP;
					end
				end
				F_RESP: begin
					fsm_q <= F_IDLE;
				end
				default: fsm_q <= F_IDLE;
			endcase
		end
	end

	// one-cycle result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= fsm_q == F_RESP;
	end

	always_ff @(posedge clk) begin
		if (fsm_q == F_RESP) begin
			rsp.iface_state      <= ist_q;
			rsp.dr_id            <= dr_q;
			rsp.bdr_id           <= bdr_q;
			rsp.roles_changed    <= chg_q;
			rsp.start_wait_timer <= stw_q;
		end
	end
endmodule

// ----- hdl/ospf_chk.sv -----
// ----------------------------------------------------------------------------
// ospf_chk
// Port-level checks on the election block's request and result timing.
// ----------------------------------------------------------------------------
module ospf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input ospf_pkg::rsp_t rsp
);
	// results never come back to back
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back to back results");

	// accepted request makes the block busy
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");

	// result ends the busy period
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy while reporting");

	// down state carries no DR or BDR
	a_down_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.iface_state == ospf_pkg::ST_DOWN) |->
		(rsp.dr_id == 32'd0 && rsp.bdr_id == 32'd0)) else $error("ids in down");
endmodule

bind ospf_dr_bdr_election ospf_chk u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

// ----- dv/ospf_dr_bdr_election_tb.sv -----
// ----------------------------------------------------------------------------
// ospf_dr_bdr_election_tb
// Self-checking bench for the DR/BDR election block: a behavioral election
// model predicts every result, directed cases walk the interface states and
// the tie and eligibility rules, then randomized table and event traffic.
// ----------------------------------------------------------------------------
module ospf_dr_bdr_election_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBR = 16;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	// commands with no meaning, expected to change nothing
	localparam logic [2:0] CMD_UNUSED_A = 3'd6;
	localparam logic [2:0] CMD_UNUSED_B = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_wdata;
	logic start;
	ospf_pkg::req_t req;
	logic busy;
	logic done;
	ospf_pkg::rsp_t rsp;

	ospf_dr_bdr_election #(.NEIGHBORS(NBR)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------- election model state ----------------
	logic [31:0] m_own_id;
	logic [7:0]  m_own_prio;
	logic        m_valid [NBR];
	logic        m_twoway [NBR];
	logic [7:0]  m_prio [NBR];
	logic [31:0] m_id [NBR];
	logic [31:0] m_ddr [NBR];
	logic [31:0] m_dbdr [NBR];
	logic [2:0]  m_state;
	logic [31:0] m_dr;
	logic [31:0] m_bdr;

	ospf_pkg::rsp_t expected_rsp_q[$];

	int errors;
	int mismatch_reports;
	int requests_sent;
	int results_seen;
	int elections_seen;
	int role_changes;
	int idle_cycles;

	// candidate slots 0..NBR-1 are neighbors, NBR is this router, -1 none
	logic [31:0] c_id [NBR+1];
	logic [31:0] c_dr [NBR+1];
	logic [31:0] c_bdr [NBR+1];
	logic [7:0]  c_prio [NBR+1];
	logic        c_elig [NBR+1];

	function automatic bit bdr_eligible(int k);
		return k >= 0 && c_elig[k] && c_dr[k] != c_id[k];
	endfunction

	function automatic bit dr_eligible(int k);
		return k >= 0 && c_elig[k] && c_dr[k] == c_id[k];
	endfunction

	// higher priority, then higher id; a kept on a full tie
	function automatic int better_of(int a, int b);
		if (c_prio[a] != c_prio[b]) return (c_prio[a] > c_prio[b]) ? a : b;
		if (c_id[a] != c_id[b]) return (c_id[a] > c_id[b]) ? a : b;
		return a;
	endfunction

	function automatic int choose_bdr(int a, int b);
		bit oa, ob, da, db;
		oa = bdr_eligible(a);
		ob = bdr_eligible(b);
		if (!oa && !ob) return -1;
		if (!oa) return b;
		if (!ob) return a;
		// a candidate declaring itself BDR is preferred
		da = c_bdr[a] == c_id[a];
		db = c_bdr[b] == c_id[b];
		if (da && !db) return a;
		if (!da && db) return b;
		return better_of(a, b);
	endfunction

	function automatic int choose_dr(int a, int b);
		bit oa, ob;
		oa = dr_eligible(a);
		ob = dr_eligible(b);
		if (!oa && !ob) return -1;
		if (!oa) return b;
		if (!ob) return a;
		return better_of(a, b);
	endfunction

	function automatic logic [31:0] cand_id(int k);
		return (k < 0) ? 32'd0 : c_id[k];
	endfunction

	// two-pass election, rerun once if this router's own role flips
	function automatic logic [2:0] run_election(output logic changed);
		int best_b, best_d, bdr, dr;
		logic [31:0] new_dr, new_bdr;
		logic [2:0] next;
		best_b = -1;
		best_d = -1;
		for (int i = 0; i < NBR; i++) begin
			c_id[i] = m_id[i];
			c_dr[i] = m_ddr[i];
			c_bdr[i] = m_dbdr[i];
			c_prio[i] = m_prio[i];
			c_elig[i] = m_twoway[i] && m_prio[i] != 8'd0;
		end
		c_id[NBR] = m_own_id;
		c_dr[NBR] = m_dr;
		c_bdr[NBR] = m_bdr;
		c_prio[NBR] = m_own_prio;
		c_elig[NBR] = m_own_prio != 8'd0;
		for (int i = 0; i < NBR; i++)
			if (m_valid[i]) best_b = choose_bdr(best_b, i);
		bdr = choose_bdr(best_b, NBR);
		for (int i = 0; i < NBR; i++)
			if (m_valid[i]) best_d = choose_dr(best_d, i);
		dr = choose_dr(best_d, NBR);
		if (dr < 0) dr = bdr;
		if (((dr == NBR) != (c_dr[NBR] == c_id[NBR])) ||
		    ((bdr == NBR) != (c_bdr[NBR] == c_id[NBR]))) begin
			c_dr[NBR] = cand_id(dr);
			c_bdr[NBR] = cand_id(bdr);
			bdr = choose_bdr(best_b, NBR);
			dr = choose_dr(best_d, NBR);
			if (dr < 0) dr = bdr;
		end
		if (dr == NBR) next = ospf_pkg::ST_DR;
		else if (bdr == NBR) next = ospf_pkg::ST_BDR;
		else next = ospf_pkg::ST_DROTHER;
		new_dr = cand_id(dr);
		new_bdr = cand_id(bdr);
		changed = (new_dr != m_dr) || (new_bdr != m_bdr);
		m_dr = new_dr;
		m_bdr = new_bdr;
		return next;
	endfunction

	// applies one request to the model and returns the predicted result
	function automatic ospf_pkg::rsp_t predict_interface(ospf_pkg::req_t r);
		ospf_pkg::rsp_t e;
		logic chg;
		logic wt;
		chg = 1'b0;
		wt = 1'b0;
		case (r.command)
			ospf_pkg::CMD_WRITE: begin
				m_valid[r.slot] = 1'b1;
				m_id[r.slot] = r.nbr_router_id;
				m_prio[r.slot] = r.nbr_priority;
				m_twoway[r.slot] = r.nbr_twoway;
				m_ddr[r.slot] = r.nbr_declared_dr;
				m_dbdr[r.slot] = r.nbr_declared_bdr;
			end
			ospf_pkg::CMD_REMOVE: m_valid[r.slot] = 1'b0;
			ospf_pkg::CMD_UP: begin
				if (r.link_up && m_state == ospf_pkg::ST_DOWN) begin
					if (r.point_to_point) m_state = ospf_pkg::ST_P2P;
					else if (m_own_prio == 8'd0) m_state = ospf_pkg::ST_DROTHER;
					else begin
						m_state = ospf_pkg::ST_WAITING;
						wt = 1'b1;
					end
				end
			end
			ospf_pkg::CMD_WAIT: begin
				if (m_state == ospf_pkg::ST_WAITING) m_state = run_election(chg);
			end
			ospf_pkg::CMD_NBRCHG: begin
				if (m_state == ospf_pkg::ST_DROTHER || m_state == ospf_pkg::ST_BDR ||
				    m_state == ospf_pkg::ST_DR)
					m_state = run_election(chg);
			end
			ospf_pkg::CMD_DOWN: begin
				m_state = ospf_pkg::ST_DOWN;
				for (int i = 0; i < NBR; i++) m_valid[i] = 1'b0;
				m_dr = 32'd0;
				m_bdr = 32'd0;
			end
			default: ;
		endcase
		e.iface_state = m_state;
		e.dr_id = m_dr;
		e.bdr_id = m_bdr;
		e.roles_changed = chg;
		e.start_wait_timer = wt;
		return e;
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			ospf_pkg::rsp_t e;
			results_seen++;
			if (expected_rsp_q.size() == 0) begin
				errors++;
				if (mismatch_reports < 10) begin
					mismatch_reports++;
					$display("ERROR: unexpected result %h", rsp);
				end
			end else begin
				e = expected_rsp_q.pop_front();
				if (e.roles_changed) role_changes++;
				if (rsp.iface_state !== e.iface_state || rsp.dr_id !== e.dr_id ||
				    rsp.bdr_id !== e.bdr_id || rsp.roles_changed !== e.roles_changed ||
				    rsp.start_wait_timer !== e.start_wait_timer) begin
					errors++;
					if (mismatch_reports < 10) begin
						mismatch_reports++;
						$display("ERROR: result %0d state exp %0d got %0d dr exp %h got %h",
							results_seen, e.iface_state, rsp.iface_state, e.dr_id, rsp.dr_id);
						$display("       bdr exp %h got %h chg exp %b got %b wt exp %b got %b",
							e.bdr_id, rsp.bdr_id, e.roles_changed, rsp.roles_changed,
							e.start_wait_timer, rsp.start_wait_timer);
					end
				end
			end
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", idle_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- driving helpers ----------------
	int burst_left;

	// sends one request, with random bursts and gaps before it
	task automatic send_request(ospf_pkg::req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 2) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		if (r.command == ospf_pkg::CMD_WAIT || r.command == ospf_pkg::CMD_NBRCHG)
			elections_seen++;
		expected_rsp_q.push_back(predict_interface(r));
		requests_sent++;
		@(negedge clk);
	endtask

	// only between phases: drain, let a trailing election finish, then write
	task automatic write_register(logic idx, logic [31:0] val);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == ospf_pkg::CFG_ROUTER_ID) m_own_id = val;
		else m_own_prio = val[7:0];
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic ospf_pkg::req_t make_cmd(logic [2:0] cmd);
		ospf_pkg::req_t r;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(ospf_pkg::req_t)-1:0];
		r.command = cmd;
		return r;
	endfunction

	function automatic ospf_pkg::req_t make_nbr(logic [3:0] s, logic [31:0] id,
			logic [7:0] p, logic tw, logic [31:0] ddr, logic [31:0] dbdr);
		ospf_pkg::req_t r;
		r = make_cmd(ospf_pkg::CMD_WRITE);
		r.slot = s;
		r.nbr_router_id = id;
		r.nbr_priority = p;
		r.nbr_twoway = tw;
		r.nbr_declared_dr = ddr;
		r.nbr_declared_bdr = dbdr;
		return r;
	endfunction

	function automatic ospf_pkg::req_t make_up(logic lu, logic p2p);
		ospf_pkg::req_t r;
		r = make_cmd(ospf_pkg::CMD_UP);
		r.link_up = lu;
		r.point_to_point = p2p;
		return r;
	endfunction

	// ---------------- tests ----------------

	// state machine corners, ties, eligibility and the no-DR fallback
	task automatic test_directed();
		send_request(make_cmd(ospf_pkg::CMD_WAIT));        // timer while down: ignored
		send_request(make_cmd(ospf_pkg::CMD_NBRCHG));      // change while down: ignored
		send_request(make_up(1'b0, 1'b0));                 // link down: ignored
		send_request(make_up(1'b1, 1'b1));                 // to point-to-point
		send_request(make_up(1'b1, 1'b0));                 // up while not down
		send_request(make_cmd(ospf_pkg::CMD_NBRCHG));      // change in p2p: ignored
		send_request(make_cmd(ospf_pkg::CMD_DOWN));
		send_request(make_cmd(CMD_UNUSED_A));              // unused commands
		send_request(make_cmd(CMD_UNUSED_B));
		// equal priority and id in two slots, one slot ineligible for zero priority, one for lack of two-way
		send_request(make_nbr(4'd0, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'd0));
		send_request(make_nbr(4'd15, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF, 32'd0));
		send_request(make_nbr(4'd7, 32'h8000_0000, 8'd0, 1'b1, 32'd0, 32'h8000_0000));
		send_request(make_nbr(4'd8, 32'h0000_0001, 8'd200, 1'b0, 32'd1, 32'd1));
		send_request(make_up(1'b1, 1'b0));                 // waiting, starts timer
		send_request(make_cmd(ospf_pkg::CMD_NBRCHG));      // change in waiting: ignored
		send_request(make_cmd(ospf_pkg::CMD_WAIT));
		send_request(make_cmd(ospf_pkg::CMD_WAIT));        // timer outside waiting
		send_request(make_cmd(ospf_pkg::CMD_REMOVE));
		send_request(make_nbr(4'd3, 32'h0000_0010, 8'd1, 1'b1, 32'd5, 32'h10));
		send_request(make_cmd(ospf_pkg::CMD_NBRCHG));
		send_request(make_cmd(ospf_pkg::CMD_DOWN));
		// no neighbor declares DR; this router's zero id matches its zero DR, so it wins DR
		send_request(make_nbr(4'd2, 32'h0000_0020, 8'd9, 1'b1, 32'd0, 32'h20));
		send_request(make_up(1'b1, 1'b0));
		send_request(make_cmd(ospf_pkg::CMD_WAIT));
	endtask

	// random traffic: mostly join / elect / change / leave sequences
	task automatic test_random(int n);
		ospf_pkg::req_t r;
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				r = make_cmd(ospf_pkg::CMD_WRITE);
				// small id pool so ties and self-declarations are common
				if ($urandom_range(0, 1)) r.nbr_router_id = $urandom_range(0, 6);
				if ($urandom_range(0, 1)) r.nbr_priority = 8'($urandom_range(0, 3));
				case ($urandom_range(0, 3))
					0: r.nbr_declared_dr = r.nbr_router_id;
					1: r.nbr_declared_dr = $urandom_range(0, 6);
					default: ;
				endcase
				case ($urandom_range(0, 3))
					0: r.nbr_declared_bdr = r.nbr_router_id;
					1: r.nbr_declared_bdr = $urandom_range(0, 6);
					default: ;
				endcase
				if ($urandom_range(0, 3) != 0) r.nbr_twoway = 1'b1;
			end else if (pick < 53) r = make_cmd(ospf_pkg::CMD_REMOVE);
			else if (pick < 63) begin
				r = make_cmd(ospf_pkg::CMD_UP);
				if ($urandom_range(0, 4) != 0) r.link_up = 1'b1;
				if ($urandom_range(0, 3) != 0) r.point_to_point = 1'b0;
			end else if (pick < 73) r = make_cmd(ospf_pkg::CMD_WAIT);
			else if (pick < 92) r = make_cmd(ospf_pkg::CMD_NBRCHG);
			else if (pick < 97) r = make_cmd(ospf_pkg::CMD_DOWN);
			else r = make_cmd(($urandom_range(0, 1)) ? CMD_UNUSED_A : CMD_UNUSED_B);
			send_request(r);
		end
	endtask

	// configuration sweep with random traffic in each setting
	task automatic test_config_sweep();
		logic [31:0] ids [4];
		logic [7:0] prios [4];
		ids = '{32'd0, 32'hFFFF_FFFF, 32'd3, 32'h5A5A_A5A5};
		prios = '{8'd0, 8'hFF, 8'd1, 8'd2};
		for (int i = 0; i < 4; i++) begin
			write_register(ospf_pkg::CFG_ROUTER_ID, ids[i]);
			write_register(ospf_pkg::CFG_PRIORITY, {24'd0, prios[i]});
			test_random(350);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		req = '0;
		errors = 0;
		mismatch_reports = 0;
		requests_sent = 0;
		results_seen = 0;
		elections_seen = 0;
		role_changes = 0;
		idle_cycles = 0;
		burst_left = 0;
		m_own_id = 32'd0;
		m_own_prio = 8'd1;
		m_state = ospf_pkg::ST_DOWN;
		m_dr = 32'd0;
		m_bdr = 32'd0;
		for (int i = 0; i < NBR; i++) begin
			m_valid[i] = 1'b0;
			m_twoway[i] = 1'b0;
			m_prio[i] = 8'd0;
			m_id[i] = 32'd0;
			m_ddr[i] = 32'd0;
			m_dbdr[i] = 32'd0;
		end
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_register(ospf_pkg::CFG_ROUTER_ID, 32'h0000_0004);
		write_register(ospf_pkg::CFG_PRIORITY, 32'd1);
		test_random(200);
		wait_quiet();                                      // sender holds until all results in
		test_config_sweep();

		wait_quiet();
		$display("covered %0d requests, %0d election events, %0d role changes",
			requests_sent, elections_seen, role_changes);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
